### hdl/mct_pkg.sv
`default_nettype none
package mct_pkg;
    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_REMOVE  = 2'd1,
        ACT_COUNT   = 2'd2,
        ACT_POPULAR = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_WRITE,
        S_OUT
    } state_t;

    localparam int COUNT_BITS = 32;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
endpackage
`default_nettype wire

### hdl/mct_cell.sv
`default_nettype none
// One slot of the table. Scan data rotates through the cells: each shift_en cycle a
// cell hands its key and count to its lower neighbor, so the head cell sees every entry.
module mct_cell
    import mct_pkg::*;
#(
    parameter int KEY_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  shift_en,
    input  wire logic                  load_en,
    input  wire logic [KEY_BITS-1:0]   load_key,
    input  wire logic [COUNT_BITS-1:0] load_count,
    input  wire logic [KEY_BITS-1:0]   nb_key,
    input  wire logic [COUNT_BITS-1:0] nb_count,
    output logic      [KEY_BITS-1:0]   key_q,
    output logic      [COUNT_BITS-1:0] count_q
);
    always_ff @(posedge aclk) begin
        if (load_en) begin
            key_q   <= load_key;
            count_q <= load_count;
        end else if (shift_en) begin
            key_q   <= nb_key;
            count_q <= nb_count;
        end
    end
endmodule
`default_nettype wire

### hdl/multiset_count_table.sv
// A result passes the rotation over all ENTRIES cells, then slot fetch, write and the
// output register. One item is in work at a time: a new input is taken only once the
// previous result has been transferred.
// Reset (aresetn, synchronous, active low) empties the table and clears m_tvalid;
// the cell contents are left as they are and are never read until written.
`default_nettype none
module multiset_count_table
    import mct_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // action[1:0], key[33:2], zero[39:34]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata   // status[1:0], amount[33:2], popular_key[65:34],
                                       // distinct[70:66], zero[71]
);
    localparam int IB = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NB = $clog2(ENTRIES + 1);

    // The cells rotate: cell i takes the contents of cell i+1, and the last cell takes
    // cell 0. After ENTRIES shifts the ring is back in place. During a rotation the
    // head (cell 0) shows slot number scan_reg.
    logic [KEY_BITS-1:0]   ck [ENTRIES];
    logic [COUNT_BITS-1:0] cc [ENTRIES];
    logic                  shift_en;
    logic [ENTRIES-1:0]    load_en;
    logic [KEY_BITS-1:0]   load_key;
    logic [COUNT_BITS-1:0] load_count;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        mct_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .aclk      (aclk),
            .shift_en  (shift_en),
            .load_en   (load_en[g]),
            .load_key  (load_key),
            .load_count(load_count),
            .nb_key    (ck[(g + 1) % ENTRIES]),
            .nb_count  (cc[(g + 1) % ENTRIES]),
            .key_q     (ck[g]),
            .count_q   (cc[g])
        );
    end

    state_t                state_reg, state_next;
    logic [NB-1:0]         used_reg, used_next;
    logic [NB-1:0]         scan_reg, scan_next;
    action_t               act_reg, act_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic                  hit_reg, hit_next;
    logic [IB-1:0]         hidx_reg, hidx_next;
    logic [COUNT_BITS-1:0] hcnt_reg, hcnt_next;
    logic [KEY_BITS-1:0]   pkey_reg, pkey_next;
    logic [COUNT_BITS-1:0] best_reg, best_next;
    logic [KEY_BITS-1:0]   lkey_reg, lkey_next;
    logic [COUNT_BITS-1:0] lcnt_reg, lcnt_next;
    logic [71:0]           out_reg, out_next;
    logic                  ov_reg, ov_next;

    status_t               r_st;
    logic [COUNT_BITS-1:0] r_amt;
    logic [31:0]           r_pk;
    logic [IB-1:0]         last_idx;

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;
    assign last_idx = IB'(used_reg - NB'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ov_reg    <= ov_next;
        end
        scan_reg <= scan_next;
        act_reg  <= act_next;
        key_reg  <= key_next;
        hit_reg  <= hit_next;
        hidx_reg <= hidx_next;
        hcnt_reg <= hcnt_next;
        pkey_reg <= pkey_next;
        best_reg <= best_next;
        lkey_reg <= lkey_next;
        lcnt_reg <= lcnt_next;
        out_reg  <= out_next;
    end

    always_comb begin
        state_next = state_reg;
        used_next  = used_reg;
        scan_next  = scan_reg;
        act_next   = act_reg;
        key_next   = key_reg;
        hit_next   = hit_reg;
        hidx_next  = hidx_reg;
        hcnt_next  = hcnt_reg;
        pkey_next  = pkey_reg;
        best_next  = best_reg;
        lkey_next  = lkey_reg;
        lcnt_next  = lcnt_reg;
        out_next   = out_reg;
        ov_next    = ov_reg;
        shift_en   = 1'b0;
        load_en    = '0;
        load_key   = key_reg;
        load_count = '0;
        r_st       = ST_OK;
        r_amt      = '0;
        r_pk       = '0;

        if (ov_reg && m_tready) ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    act_next   = action_t'(s_tdata[1:0]);
                    key_next   = KEY_BITS'(s_tdata[33:2]);
                    scan_next  = '0;
                    hit_next   = 1'b0;
                    best_next  = '0;
                    pkey_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // Head cell holds slot scan_reg; a full rotation restores the ring.
                if (scan_reg < used_reg) begin
                    if (!hit_reg && ck[0] == key_reg) begin
                        hit_next  = 1'b1;
                        hidx_next = IB'(scan_reg);
                        hcnt_next = cc[0];
                    end
                    if (scan_reg == '0 || cc[0] > best_reg) begin
                        best_next = cc[0];
                        pkey_next = ck[0];
                    end
                end
                shift_en  = 1'b1;
                scan_next = scan_reg + NB'(1);
                if (scan_reg == NB'(ENTRIES - 1)) state_next = S_FETCH;
            end
            S_FETCH: begin
                // The last slot is read from its fixed cell for the remove move.
                lkey_next  = ck[last_idx];
                lcnt_next  = cc[last_idx];
                state_next = S_WRITE;
            end
            S_WRITE: begin
                unique case (act_reg)
                    ACT_ADD: begin
                        if (hit_reg) begin
                            load_count = (hcnt_reg == COUNT_MAX) ? hcnt_reg
                                                                 : hcnt_reg + 1'b1;
                            load_key   = key_reg;
                            load_en[hidx_reg] = 1'b1;
                            r_amt = load_count;
                        end else if (used_reg >= NB'(ENTRIES)) begin
                            r_st = ST_FULL;
                        end else begin
                            load_key   = key_reg;
                            load_count = COUNT_BITS'(1);
                            load_en[IB'(used_reg)] = 1'b1;
                            used_next = used_reg + NB'(1);
                            r_amt = COUNT_BITS'(1);
                        end
                    end
                    ACT_REMOVE: begin
                        if (!hit_reg) begin
                            r_st = ST_MISSING;
                        end else if (hcnt_reg <= COUNT_BITS'(1)) begin
                            load_key   = lkey_reg;
                            load_count = lcnt_reg;
                            load_en[hidx_reg] = 1'b1;
                            used_next = used_reg - NB'(1);
                        end else begin
                            load_key   = key_reg;
                            load_count = hcnt_reg - 1'b1;
                            load_en[hidx_reg] = 1'b1;
                            r_amt = load_count;
                        end
                    end
                    ACT_COUNT: begin
                        if (hit_reg) r_amt = hcnt_reg;
                        else r_st = ST_MISSING;
                    end
                    ACT_POPULAR: begin
                        if (used_reg == '0) begin
                            r_st = ST_EMPTY;
                        end else begin
                            r_amt = best_reg;
                            r_pk  = 32'(pkey_reg);
                        end
                    end
                    default: ;
                endcase
                out_next   = {1'b0, 5'(used_next), r_pk, r_amt, r_st};
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // A result is only raised at the end of a write step.
    a_out_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_WRITE)
        else $error("result raised outside write step");
    // The table never holds more than ENTRIES keys.
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= NB'(ENTRIES))
        else $error("entry count overflow");
    // Entry count moves by at most one per item, only in the write step.
    a_used_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_WRITE) |=> $stable(used_reg))
        else $error("entry count changed outside write");
endmodule
`default_nettype wire
